/* src/ctst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and keyword tables for the character stream tokenizer.
package ctst_pkg;

   localparam int FIELD_W = 16;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   typedef enum logic [2:0] {
      KIND_NUMBER,
      KIND_OPERATOR,
      KIND_KEYWORD,
      KIND_IDENT,
      KIND_STRING,
      KIND_DELIM,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_INVALID,
      ERR_STRING,
      ERR_COMMENT
   } err_type;

   typedef enum logic [1:0] {
      KW_IF,
      KW_REPEAT,
      KW_UNTIL,
      KW_NONE
   } kw_type;

   typedef struct packed {
      kind_type             kind;
      err_type              error_code;
      kw_type               keyword_index;
      logic [FIELD_W-1:0]   start_offset;
      logic [FIELD_W-1:0]   length;
      logic [FIELD_W-1:0]   line;
      logic [7:0]           char_value;
      logic                 last;
   } result_type;

   // Results produced by one scan step, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam logic [7:0] KW_TEXT [3][8] = '{
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74, 8'h00, 8'h00},
      '{8'h75, 8'h6E, 8'h74, 8'h69, 8'h6C, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [3] = '{3'd2, 3'd6, 3'd5};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

endpackage

/* src/char_stream_tokenizer_unit.sv */
`timescale 1ns / 1ps
// Top level of the character stream tokenizer: request register, scanner and result queue.
//
//   Channel   Ports                       Direction   Content
//   request   req_valid/req_ready/req_*   in          one source byte or end mark
//   response  rsp_valid/rsp_ready/rsp_*   out         one token descriptor
//
// A request is registered, scanned once the queue has room for its tokens, and its tokens
// are written to a four-entry queue whose head drives the response port.
// One request is taken every cycle while the queue has room for two tokens; the response
// port drains one token per cycle while rsp_ready is high.
// Reset returns the scan to line 1, offset 0, and empties the queue.
// A stalled response side fills the queue, which then holds the request register.
module char_stream_tokenizer_unit
   import ctst_pkg::*;
#(
   parameter int OFFSET_BITS = 16,
   parameter int LINE_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_ch,
   input  logic         req_is_end,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_kind,
   output logic [1:0]   rsp_error_code,
   output logic [1:0]   rsp_keyword_index,
   output logic [15:0]  rsp_start_offset,
   output logic [15:0]  rsp_length,
   output logic [15:0]  rsp_line,
   output logic [7:0]   rsp_char_value,
   output logic         rsp_last
);

   logic               in_valid_ff;
   logic [7:0]         in_ch_ff;
   logic               in_end_ff;
   logic               take;
   logic [Q_CNT_W-1:0] q_count;
   push_type           push;
   result_type         head;

   assign take      = in_valid_ff && (q_count <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_is_end;
      end
   end

   ctst_scanner #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS  (LINE_BITS)
   ) u_scanner (
      .clock  (clock),
      .reset  (reset),
      .step_en(take),
      .ch     (in_ch_ff),
      .is_end (in_end_ff),
      .push   (push)
   );

   ctst_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_ready),
      .head      (head),
      .head_valid(rsp_valid),
      .count     (q_count)
   );

   assign rsp_kind          = head.kind;
   assign rsp_error_code    = head.error_code;
   assign rsp_keyword_index = head.keyword_index;
   assign rsp_start_offset  = head.start_offset;
   assign rsp_length        = head.length;
   assign rsp_line          = head.line;
   assign rsp_char_value    = head.char_value;
   assign rsp_last          = head.last;

endmodule

/* src/ctst_scanner.sv */
`timescale 1ns / 1ps
// Scan state machine: consumes one registered byte per step and forms up to two tokens.
module ctst_scanner
   import ctst_pkg::*;
#(
   parameter int OFFSET_BITS = 16,
   parameter int LINE_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] ch,
   input  logic       is_end,
   output push_type   push
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_STR,
      MODE_SLASH,
      MODE_LINEC,
      MODE_BLOCK,
      MODE_STAR
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [OFFSET_BITS-1:0] tstart_ff, tstart_in;
   logic [OFFSET_BITS-1:0] tlen_ff, tlen_in;
   logic [LINE_BITS-1:0]   tline_ff, tline_in;
   logic [2:0]             kwm_ff, kwm_in;

   result_type ra, rb;
   logic       va, vb;
   logic       handled;
   logic       end_m;
   logic       bad;
   kw_type     kw_sel;

   function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [2:0] kw_step(input logic [2:0] kwm,
                                          input logic [OFFSET_BITS-1:0] len,
                                          input logic [7:0] c);
      logic [2:0] k;
      k = kwm;
      for (int i = 0; i < 3; i++) begin
         if ((len >= OFFSET_BITS'(KW_LEN[i])) || (KW_TEXT[i][len[2:0]] != c)) begin
            k[i] = 1'b0;
         end
      end
      return k;
   endfunction

   function automatic kw_type kw_pick(input logic [2:0] kwm,
                                      input logic [OFFSET_BITS-1:0] len);
      kw_type k;
      if (kwm[0] && (len == OFFSET_BITS'(KW_LEN[0]))) begin
         k = KW_IF;
      end else if (kwm[1] && (len == OFFSET_BITS'(KW_LEN[1]))) begin
         k = KW_REPEAT;
      end else if (kwm[2] && (len == OFFSET_BITS'(KW_LEN[2]))) begin
         k = KW_UNTIL;
      end else begin
         k = KW_NONE;
      end
      return k;
   endfunction

   function automatic result_type mk(input kind_type kind, input err_type err,
                                     input kw_type kw,
                                     input logic [OFFSET_BITS-1:0] start,
                                     input logic [OFFSET_BITS-1:0] len,
                                     input logic [LINE_BITS-1:0] ln,
                                     input logic [7:0] chr);
      result_type r;
      r.kind          = kind;
      r.error_code    = err;
      r.keyword_index = kw;
      r.start_offset  = FIELD_W'(start);
      r.length        = FIELD_W'(len);
      r.line          = FIELD_W'(ln);
      r.char_value    = chr;
      r.last          = 1'b0;
      return r;
   endfunction

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      off_in    = off_inc(off_ff);
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      tline_in  = tline_ff;
      kwm_in    = kwm_ff;
      ra        = '0;
      rb        = '0;
      va        = 1'b0;
      vb        = 1'b0;
      handled   = 1'b0;
      end_m     = is_end || (ch == CH_NUL);
      bad       = !end_m && is_alpha(ch);
      kw_sel    = kw_pick(kwm_ff, tlen_ff);

      unique case (mode_ff)
         MODE_NUM: begin
            if (!end_m && is_digit(ch)) begin
               tlen_in = off_inc(tlen_ff);
               handled = 1'b1;
            end else begin
               ra = mk(KIND_NUMBER, bad ? ERR_INVALID : ERR_NONE, KW_NONE, tstart_ff,
                       tlen_ff, tline_ff, bad ? ch : CH_NUL);
               va = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (!end_m && (is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER))) begin
               kwm_in  = kw_step(kwm_ff, tlen_ff, ch);
               tlen_in = off_inc(tlen_ff);
               handled = 1'b1;
            end else begin
               ra = mk((kw_sel != KW_NONE) ? KIND_KEYWORD : KIND_IDENT, ERR_NONE, kw_sel,
                       tstart_ff, tlen_ff, tline_ff, CH_NUL);
               va = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_STR: begin
            if (!end_m && (ch == CH_QUOTE)) begin
               ra = mk(KIND_STRING, ERR_NONE, KW_NONE, tstart_ff, tlen_ff, tline_ff, CH_NUL);
               va = 1'b1;
               mode_in = MODE_IDLE;
               handled = 1'b1;
            end else if (!end_m && (ch != CH_NL)) begin
               tlen_in = off_inc(tlen_ff);
               handled = 1'b1;
            end else begin
               ra = mk(KIND_ERROR, ERR_STRING, KW_NONE, tstart_ff, tlen_ff, tline_ff, CH_NUL);
               va = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_SLASH: begin
            if (!end_m && ((ch == CH_SLASH) || (ch == CH_STAR))) begin
               mode_in = (ch == CH_SLASH) ? MODE_LINEC : MODE_BLOCK;
               tlen_in = off_inc(tlen_ff);
               handled = 1'b1;
            end else begin
               ra = mk(KIND_ERROR, ERR_INVALID, KW_NONE, tstart_ff, OFFSET_BITS'(1),
                       tline_ff, CH_SLASH);
               va = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_LINEC: begin
            if (end_m || (ch == CH_NL)) begin
               mode_in = MODE_IDLE;
            end else begin
               handled = 1'b1;
            end
         end
         MODE_BLOCK, MODE_STAR: begin
            if (end_m) begin
               ra = mk(KIND_ERROR, ERR_COMMENT, KW_NONE, tstart_ff, tlen_ff, tline_ff, CH_NUL);
               va = 1'b1;
               mode_in = MODE_IDLE;
            end else begin
               tlen_in = off_inc(tlen_ff);
               if ((mode_ff == MODE_STAR) && (ch == CH_SLASH)) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = (ch == CH_STAR) ? MODE_STAR : MODE_BLOCK;
               end
               if (ch == CH_NL) begin
                  line_in = line_inc(line_ff);
               end
               handled = 1'b1;
            end
         end
         MODE_IDLE: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (!handled) begin
         if (end_m) begin
            rb = mk(KIND_END, ERR_NONE, KW_NONE, off_ff, '0, line_in, CH_NUL);
            vb = 1'b1;
            mode_in   = MODE_IDLE;
            line_in   = LINE_BITS'(1);
            off_in    = '0;
            tstart_in = '0;
            tlen_in   = '0;
            tline_in  = LINE_BITS'(1);
            kwm_in    = 3'b111;
         end else if (ch == CH_NL) begin
            line_in = line_inc(line_ff);
         end else if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
            mode_in = MODE_IDLE;
         end else if (is_digit(ch)) begin
            tstart_in = off_ff;
            tlen_in   = OFFSET_BITS'(1);
            tline_in  = line_in;
            mode_in   = MODE_NUM;
         end else if (is_alpha(ch)) begin
            tstart_in = off_ff;
            tlen_in   = OFFSET_BITS'(1);
            tline_in  = line_in;
            kwm_in    = kw_step(3'b111, '0, ch);
            mode_in   = MODE_IDENT;
         end else if ((ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_EQUAL)) begin
            rb = mk(KIND_OPERATOR, ERR_NONE, KW_NONE, off_ff, OFFSET_BITS'(1), line_in, ch);
            vb = 1'b1;
         end else if (ch == CH_SEMI) begin
            rb = mk(KIND_DELIM, ERR_NONE, KW_NONE, off_ff, OFFSET_BITS'(1), line_in, ch);
            vb = 1'b1;
         end else if (ch == CH_QUOTE) begin
            tstart_in = off_inc(off_ff);
            tlen_in   = '0;
            tline_in  = line_in;
            mode_in   = MODE_STR;
         end else if (ch == CH_SLASH) begin
            tstart_in = off_ff;
            tlen_in   = OFFSET_BITS'(1);
            tline_in  = line_in;
            mode_in   = MODE_SLASH;
         end else begin
            rb = mk(KIND_ERROR, ERR_INVALID, KW_NONE, off_ff, OFFSET_BITS'(1), line_in, ch);
            vb = 1'b1;
         end
      end

      push.count       = step_en ? (2'(va) + 2'(vb)) : 2'd0;
      push.first       = va ? ra : rb;
      push.first.last  = !(va && vb);
      push.second      = rb;
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         off_ff    <= '0;
         tstart_ff <= '0;
         tlen_ff   <= '0;
         tline_ff  <= LINE_BITS'(1);
         kwm_ff    <= 3'b111;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         off_ff    <= off_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
         tline_ff  <= tline_in;
         kwm_ff    <= kwm_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) line_ff != '0)
      else $error("Line counter reached zero.");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && vb && (rb.kind == KIND_END)) |=> ((off_ff == '0) && (mode_ff == MODE_IDLE)))
      else $error("End token did not restart the scan.");

   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.kind != KIND_END))
      else $error("End token was not the final result of its request.");

endmodule

/* src/ctst_result_queue.sv */
`timescale 1ns / 1ps
// Four-entry result queue taking up to two tokens per cycle and delivering one while pop_ready is high.
module ctst_result_queue
   import ctst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   input  logic               pop_ready,
   output result_type         head,
   output logic               head_valid,
   output logic [Q_CNT_W-1:0] count
);

   result_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               pop;

   assign pop        = (cnt_ff != '0) && pop_ready;
   assign head       = mem_ff[rd_ff];
   assign head_valid = cnt_ff != '0;
   assign count      = cnt_ff;

   always_comb begin
      wr_in  = wr_ff + Q_PTR_W'(push.count);
      rd_in  = rd_ff + Q_PTR_W'(pop);
      cnt_in = cnt_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[Q_PTR_W'(wr_ff + 1'b1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("Result queue count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (cnt_ff <= Q_CNT_W'(Q_DEPTH - 2)))
      else $error("Result queue written without room for two results.");

endmodule
